// ===== rtl/core/atbd_pkg.sv =====
// Shared definitions for the broadcast text byte decoder.
// Set and class codes, control bytes, queue item type and set lookups.
// No dependencies.
`default_nettype none

package atbd_pkg;

  // Graphic set codes held in the G0..G3 designations
  localparam logic [3:0] SET_UNKNOWN    = 4'd0;
  localparam logic [3:0] SET_KANJI      = 4'd1;
  localparam logic [3:0] SET_ALNUM      = 4'd2;
  localparam logic [3:0] SET_HIRA       = 4'd3;
  localparam logic [3:0] SET_KATA       = 4'd4;
  localparam logic [3:0] SET_MOSAIC_A   = 4'd5;
  localparam logic [3:0] SET_MOSAIC_B   = 4'd6;
  localparam logic [3:0] SET_MOSAIC_C   = 4'd7;
  localparam logic [3:0] SET_MOSAIC_D   = 4'd8;
  localparam logic [3:0] SET_PROP_ALNUM = 4'd9;
  localparam logic [3:0] SET_PROP_HIRA  = 4'd10;
  localparam logic [3:0] SET_PROP_KATA  = 4'd11;
  localparam logic [3:0] SET_JIS_KATA   = 4'd12;
  localparam logic [3:0] SET_JIS_K1     = 4'd13;
  localparam logic [3:0] SET_JIS_K2     = 4'd14;
  localparam logic [3:0] SET_SYMBOLS    = 4'd15;

  // Character classes on the result channel
  localparam logic [2:0] CLS_SPACE    = 3'd0;
  localparam logic [2:0] CLS_NEWLINE  = 3'd1;
  localparam logic [2:0] CLS_KANJI    = 3'd2;
  localparam logic [2:0] CLS_ALNUM    = 3'd3;
  localparam logic [2:0] CLS_HIRA     = 3'd4;
  localparam logic [2:0] CLS_KATA     = 3'd5;
  localparam logic [2:0] CLS_JIS_KATA = 3'd6;
  localparam logic [2:0] CLS_SYMBOL   = 3'd7;

  // Control bytes
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_LS1   = 8'h0E;
  localparam logic [7:0] BYTE_LS0   = 8'h0F;
  localparam logic [7:0] BYTE_SS2   = 8'h19;
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_SS3   = 8'h1D;
  localparam logic [7:0] BYTE_SP    = 8'h20;
  localparam logic [7:0] BYTE_GR_SP = 8'hA0;

  // Queue between front and back (depth must be a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One classified character travelling from front to back
  typedef struct packed {
    logic [2:0]  cls;
    logic [14:0] code;
  } atbd_item_t;

  // Escape sequence progress
  typedef enum logic [4:0] {
    ESC_IDLE = 5'b00001,
    ESC_1    = 5'b00010,
    ESC_2    = 5'b00100,
    ESC_3    = 5'b01000,
    ESC_4    = 5'b10000
  } esc_state_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] cls;
  } cls_lookup_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] set;
  } set_lookup_t;

  // Two-byte sets take a lead and a trail byte
  function automatic logic is_double(input logic [3:0] set);
    return (set == SET_KANJI) || (set == SET_JIS_K1) || (set == SET_JIS_K2) ||
           (set == SET_SYMBOLS);
  endfunction

  // Class of a set; mosaic, DRCS and unknown sets have none
  function automatic cls_lookup_t class_of(input logic [3:0] set);
    cls_lookup_t r;
    r.ok = 1'b1;
    unique case (set)
      SET_KANJI, SET_JIS_K1, SET_JIS_K2: r.cls = CLS_KANJI;
      SET_ALNUM, SET_PROP_ALNUM:         r.cls = CLS_ALNUM;
      SET_HIRA, SET_PROP_HIRA:           r.cls = CLS_HIRA;
      SET_KATA, SET_PROP_KATA:           r.cls = CLS_KATA;
      SET_JIS_KATA:                      r.cls = CLS_JIS_KATA;
      SET_SYMBOLS:                       r.cls = CLS_SYMBOL;
      default: begin
        r.ok  = 1'b0;
        r.cls = CLS_SPACE;
      end
    endcase
    return r;
  endfunction

  // Final byte of a graphic set designation
  function automatic set_lookup_t designate_set(input logic [7:0] b);
    set_lookup_t r;
    r.ok = 1'b1;
    unique case (b)
      8'h42:   r.set = SET_KANJI;
      8'h4A:   r.set = SET_ALNUM;
      8'h30:   r.set = SET_HIRA;
      8'h31:   r.set = SET_KATA;
      8'h32:   r.set = SET_MOSAIC_A;
      8'h33:   r.set = SET_MOSAIC_B;
      8'h34:   r.set = SET_MOSAIC_C;
      8'h35:   r.set = SET_MOSAIC_D;
      8'h36:   r.set = SET_PROP_ALNUM;
      8'h37:   r.set = SET_PROP_HIRA;
      8'h38:   r.set = SET_PROP_KATA;
      8'h49:   r.set = SET_JIS_KATA;
      8'h39:   r.set = SET_JIS_K1;
      8'h3A:   r.set = SET_JIS_K2;
      8'h3B:   r.set = SET_SYMBOLS;
      default: begin
        r.ok  = 1'b0;
        r.set = SET_UNKNOWN;
      end
    endcase
    return r;
  endfunction

  // Final byte of a DRCS designation
  function automatic logic drcs_ok(input logic [7:0] b);
    return (b[7:4] == 4'h4) || (b == 8'h70);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/atbd_front.sv =====
// Front of the text byte decoder: code set state, escape parsing, lead bytes.
// Classifies each accepted byte and pushes completed characters to the queue.
// Depends on atbd_pkg.
`default_nettype none

module atbd_front
  import atbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] src_byte,
  input  wire logic       last_byte,
  output logic            push,
  output atbd_item_t      item
);

  logic [3:0] g_r [4];
  logic [3:0] g_nxt [4];
  logic [1:0] gl_r, gl_nxt;
  logic [1:0] gr_r, gr_nxt;
  logic [2:0] ss_r, ss_nxt;
  esc_state_t esc_r, esc_nxt;
  logic [1:0] tgt_r, tgt_nxt;
  logic       drcs_r, drcs_nxt;
  logic       lead_v_r, lead_v_nxt;
  logic [6:0] lead_code_r, lead_code_nxt;
  logic [3:0] lead_set_r, lead_set_nxt;
  logic       lead_gr_r, lead_gr_nxt;

  logic [1:0]  sel_idx;
  logic [3:0]  sel_set;
  set_lookup_t dset;
  logic        drcs_hit;
  logic [7:0]  trail;
  cls_lookup_t lead_cls;
  cls_lookup_t byte_cls;
  logic        is_gl;
  logic        is_gr;

  // Pick the one designation this byte can use
  assign is_gl    = (src_byte >= 8'h21) && (src_byte <= 8'h7E);
  assign is_gr    = (src_byte >= 8'hA1) && (src_byte <= 8'hFE);
  assign sel_idx  = src_byte[7] ? gr_r : (ss_r[2] ? ss_r[1:0] : gl_r);
  assign sel_set  = g_r[sel_idx];
  assign dset     = designate_set(src_byte);
  assign drcs_hit = drcs_ok(src_byte);
  assign trail    = lead_gr_r ? {1'b0, src_byte[6:0]} : src_byte;
  assign lead_cls = class_of(lead_set_r);
  assign byte_cls = class_of(sel_set);

  // Decode the byte against the current state
  always_comb begin
    g_nxt         = g_r;
    gl_nxt        = gl_r;
    gr_nxt        = gr_r;
    ss_nxt        = ss_r;
    esc_nxt       = esc_r;
    tgt_nxt       = tgt_r;
    drcs_nxt      = drcs_r;
    lead_v_nxt    = lead_v_r;
    lead_code_nxt = lead_code_r;
    lead_set_nxt  = lead_set_r;
    lead_gr_nxt   = lead_gr_r;
    push          = 1'b0;
    item          = '0;

    if (accept) begin
      priority if (lead_v_r) begin
        // Trail byte: complete the two-byte code
        lead_v_nxt = 1'b0;
        push       = lead_cls.ok;
        item.cls   = lead_cls.cls;
        item.code  = {lead_code_r, trail};
      end else if (esc_r != ESC_IDLE) begin
        unique case (esc_r)
          ESC_1: begin
            esc_nxt = ESC_IDLE;
            unique case (src_byte)
              8'h6E: gl_nxt = 2'd2;
              8'h6F: gl_nxt = 2'd3;
              8'h7E: gr_nxt = 2'd1;
              8'h7D: gr_nxt = 2'd2;
              8'h7C: gr_nxt = 2'd3;
              8'h24, 8'h28: begin
                tgt_nxt = 2'd0;
                esc_nxt = ESC_2;
              end
              8'h29: begin
                tgt_nxt = 2'd1;
                esc_nxt = ESC_2;
              end
              8'h2A: begin
                tgt_nxt = 2'd2;
                esc_nxt = ESC_2;
              end
              8'h2B: begin
                tgt_nxt = 2'd3;
                esc_nxt = ESC_2;
              end
              default: esc_nxt = ESC_IDLE;
            endcase
          end
          ESC_2: begin
            esc_nxt = ESC_IDLE;
            if (dset.ok) begin
              g_nxt[tgt_r] = dset.set;
            end else begin
              unique case (src_byte)
                8'h20: begin
                  drcs_nxt = 1'b1;
                  esc_nxt  = ESC_3;
                end
                8'h28: begin
                  drcs_nxt = 1'b1;
                  tgt_nxt  = 2'd0;
                  esc_nxt  = ESC_3;
                end
                8'h29: begin
                  drcs_nxt = 1'b0;
                  tgt_nxt  = 2'd1;
                  esc_nxt  = ESC_3;
                end
                8'h2A: begin
                  drcs_nxt = 1'b0;
                  tgt_nxt  = 2'd2;
                  esc_nxt  = ESC_3;
                end
                8'h2B: begin
                  drcs_nxt = 1'b0;
                  tgt_nxt  = 2'd3;
                  esc_nxt  = ESC_3;
                end
                default: esc_nxt = ESC_IDLE;
              endcase
            end
          end
          ESC_3: begin
            esc_nxt = ESC_IDLE;
            if (drcs_r ? drcs_hit : dset.ok) begin
              g_nxt[tgt_r] = drcs_r ? SET_UNKNOWN : dset.set;
            end else if (src_byte == BYTE_SP) begin
              drcs_nxt = 1'b1;
              esc_nxt  = ESC_4;
            end
          end
          ESC_4: begin
            esc_nxt = ESC_IDLE;
            if (drcs_hit) begin
              g_nxt[tgt_r] = SET_UNKNOWN;
            end
          end
          default: esc_nxt = ESC_IDLE;
        endcase
      end else if (is_gl || is_gr) begin
        // Graphic byte: single shift applies to GL only
        if (is_gl) begin
          ss_nxt = 3'd0;
        end
        if (is_double(sel_set)) begin
          if (!last_byte) begin
            lead_v_nxt    = 1'b1;
            lead_code_nxt = src_byte[6:0];
            lead_set_nxt  = sel_set;
            lead_gr_nxt   = is_gr;
          end
        end else begin
          push      = byte_cls.ok;
          item.cls  = byte_cls.cls;
          item.code = is_gr ? {8'd0, src_byte[6:0]} : {7'd0, src_byte};
        end
      end else begin
        // Control codes; anything else is ignored
        unique case (src_byte)
          BYTE_LS0: gl_nxt = 2'd0;
          BYTE_LS1: gl_nxt = 2'd1;
          BYTE_SS2: ss_nxt = 3'b110;
          BYTE_SS3: ss_nxt = 3'b111;
          BYTE_ESC: esc_nxt = ESC_1;
          BYTE_SP, BYTE_GR_SP: begin
            push      = 1'b1;
            item.cls  = CLS_SPACE;
            item.code = {7'd0, BYTE_SP};
          end
          BYTE_CR: begin
            push      = 1'b1;
            item.cls  = CLS_NEWLINE;
            item.code = {7'd0, BYTE_CR};
          end
          default: ;
        endcase
      end

      // Return to the initial state after the last byte of a string
      if (last_byte) begin
        g_nxt[0]      = SET_KANJI;
        g_nxt[1]      = SET_ALNUM;
        g_nxt[2]      = SET_HIRA;
        g_nxt[3]      = SET_KATA;
        gl_nxt        = 2'd0;
        gr_nxt        = 2'd2;
        ss_nxt        = 3'd0;
        esc_nxt       = ESC_IDLE;
        tgt_nxt       = 2'd0;
        drcs_nxt      = 1'b0;
        lead_v_nxt    = 1'b0;
        lead_code_nxt = 7'd0;
        lead_set_nxt  = SET_UNKNOWN;
        lead_gr_nxt   = 1'b0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r[0]   <= SET_KANJI;
      g_r[1]   <= SET_ALNUM;
      g_r[2]   <= SET_HIRA;
      g_r[3]   <= SET_KATA;
      gl_r     <= 2'd0;
      gr_r     <= 2'd2;
      ss_r     <= 3'd0;
      esc_r    <= ESC_IDLE;
      tgt_r    <= 2'd0;
      drcs_r   <= 1'b0;
      lead_v_r <= 1'b0;
    end else begin
      g_r      <= g_nxt;
      gl_r     <= gl_nxt;
      gr_r     <= gr_nxt;
      ss_r     <= ss_nxt;
      esc_r    <= esc_nxt;
      tgt_r    <= tgt_nxt;
      drcs_r   <= drcs_nxt;
      lead_v_r <= lead_v_nxt;
    end
  end

  // Lead byte payload
  always_ff @(posedge clk) begin
    lead_code_r <= lead_code_nxt;
    lead_set_r  <= lead_set_nxt;
    lead_gr_r   <= lead_gr_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/atbd_queue.sv =====
// Short queue of classified characters between decoder front and back.
// Flip-flop storage, one push while not full and one pop while not empty per cycle.
// Depends on atbd_pkg.
`default_nettype none

module atbd_queue
  import atbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire atbd_item_t push_item,
  input  wire logic       pop,
  output logic            full,
  output logic            head_valid,
  output atbd_item_t      head_item
);

  atbd_item_t             q_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = q_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Write the entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow push");

endmodule

`default_nettype wire

// ===== rtl/core/atbd_back.sv =====
// Back of the text byte decoder: Shift-JIS and symbol row lookup, output register.
// Takes characters from the queue and presents them on the result channel.
// Depends on atbd_pkg.
`default_nettype none

module atbd_back
  import atbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  wire atbd_item_t head_item,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_char_class,
  output logic [14:0]     out_char_code,
  output logic [15:0]     out_shift_jis_code,
  output logic [2:0]      out_symbol_row,
  output logic [6:0]      out_symbol_offset
);

  // Additional symbol ranges
  localparam logic [14:0] SYM0_LO = 15'h7A50;
  localparam logic [14:0] SYM0_HI = 15'h7A74;
  localparam logic [14:0] SYM1_LO = 15'h7C21;
  localparam logic [14:0] SYM1_HI = 15'h7C7B;
  localparam logic [14:0] SYM2_LO = 15'h7D21;
  localparam logic [14:0] SYM2_HI = 15'h7D7B;
  localparam logic [14:0] SYM3_LO = 15'h7E21;
  localparam logic [14:0] SYM3_HI = 15'h7E7D;
  localparam logic [2:0]  SYM_ROW_NONE = 3'd4;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  cls_r;
  logic [14:0] code_r;
  logic [15:0] sjis_r, sjis_nxt;
  logic [2:0]  row_r, row_nxt;
  logic [6:0]  off_r, off_nxt;
  logic [14:0] diff;

  // JIS row/cell to Shift-JIS
  function automatic logic [15:0] to_sjis(input logic [14:0] code);
    logic [6:0] h;
    logic [8:0] lo;
    logic [5:0] hh;
    logic [7:0] hi;
    h = code[14:8] - 7'h21;
    if (h[0]) begin
      lo = {1'b0, code[7:0]} + 9'h07E;
    end else begin
      lo = {1'b0, code[7:0]} + 9'h01F;
      if ((lo >= 9'h07F) && (lo <= 9'h09D)) begin
        lo = lo + 9'd1;
      end
    end
    hh = h[6:1];
    hi = (hh <= 6'h1E) ? ({2'b00, hh} + 8'h81) : ({2'b00, hh} + 8'hC1);
    return {hi, lo[7:0]};
  endfunction

  // Load the output register whenever it is empty or being taken
  assign pop           = head_valid && (!out_valid_r || out_ready);
  assign out_valid_nxt = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Work out Shift-JIS and symbol position of the head character
  always_comb begin
    sjis_nxt = '0;
    row_nxt  = '0;
    off_nxt  = '0;
    diff     = '0;
    if (head_item.cls == CLS_KANJI) begin
      sjis_nxt = to_sjis(head_item.code);
    end
    if (head_item.cls == CLS_SYMBOL) begin
      priority if ((head_item.code >= SYM0_LO) && (head_item.code <= SYM0_HI)) begin
        row_nxt = 3'd0;
        diff    = head_item.code - SYM0_LO;
      end else if ((head_item.code >= SYM1_LO) && (head_item.code <= SYM1_HI)) begin
        row_nxt = 3'd1;
        diff    = head_item.code - SYM1_LO;
      end else if ((head_item.code >= SYM2_LO) && (head_item.code <= SYM2_HI)) begin
        row_nxt = 3'd2;
        diff    = head_item.code - SYM2_LO;
      end else if ((head_item.code >= SYM3_LO) && (head_item.code <= SYM3_HI)) begin
        row_nxt = 3'd3;
        diff    = head_item.code - SYM3_LO;
      end else begin
        row_nxt = SYM_ROW_NONE;
      end
      off_nxt = diff[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cls_r  <= head_item.cls;
      code_r <= head_item.code;
      sjis_r <= sjis_nxt;
      row_r  <= row_nxt;
      off_r  <= off_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_char_class     = cls_r;
  assign out_char_code      = code_r;
  assign out_shift_jis_code = sjis_r;
  assign out_symbol_row     = row_r;
  assign out_symbol_offset  = off_r;

endmodule

`default_nettype wire

// ===== rtl/core/arib_text_byte_decoder.sv =====
// Broadcast 8-unit text byte decoder, top level.
// Input channel: one raw string byte per request (in_src_byte) with
// in_last_byte marking the final byte of a string. The decoder keeps the
// G0..G3 designations, GL/GR invocations, single shift, escape progress and
// a pending lead byte, and returns all of it to the initial state after the
// last byte.
// Result channel: one request per completed character with class, code,
// Shift-JIS code (kanji class) and symbol row/offset (symbol class).
// Control bytes other than the spaces and CR, escape bytes, lead bytes and
// characters of mosaic, DRCS or unknown sets give no result.
// Throughput: one byte per cycle while in_ready is high. A result is
// written into the queue when its completing byte is accepted, then
// moves into the output register once that register is empty or being
// taken by the receiver.
// When the receiver stalls, the two-entry queue and the output register
// absorb results; in_ready falls once the queue is full.
// Reset (rst_n low, synchronous) restores the initial code set state and
// empties queue and output register.
// Depends on atbd_pkg, atbd_front, atbd_queue, atbd_back.
`default_nettype none

module arib_text_byte_decoder
  import atbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_src_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_char_class,
  output logic [14:0]      out_char_code,
  output logic [15:0]      out_shift_jis_code,
  output logic [2:0]       out_symbol_row,
  output logic [6:0]       out_symbol_offset
);

  logic       accept;
  logic       push;
  atbd_item_t push_item;
  logic       q_full;
  logic       pop;
  logic       head_valid;
  atbd_item_t head_item;

  // Take a byte whenever the queue has room for its result
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  atbd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .src_byte  (in_src_byte),
    .last_byte (in_last_byte),
    .push      (push),
    .item      (push_item)
  );

  atbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  atbd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_valid         (head_valid),
    .head_item          (head_item),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char_class     (out_char_class),
    .out_char_code      (out_char_code),
    .out_shift_jis_code (out_shift_jis_code),
    .out_symbol_row     (out_symbol_row),
    .out_symbol_offset  (out_symbol_offset)
  );

endmodule

`default_nettype wire
